[rtl/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and the sRGB linearization table for the contrast
// ratio unit.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int LUM_W      = 17;   // Q0.16 luminance, 0 .. 65536
    localparam int RATIO_W    = 21;   // Q5.16 contrast ratio
    localparam int PROD_W     = 32;   // one weighted channel
    localparam int SUM_W      = 33;   // sum of three weighted channels
    localparam int N_CELLS    = RATIO_W;
    localparam int LUMA_DEPTH = 3;
    localparam int N_STAGES   = LUMA_DEPTH + 1 + N_CELLS;

    localparam logic [15:0]      COEF_R     = 16'd13933;
    localparam logic [15:0]      COEF_G     = 16'd46871;
    localparam logic [15:0]      COEF_B     = 16'd4732;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
    localparam logic [LUM_W-1:0] FLARE      = LUM_W'(3277);
    localparam logic [LUM_W-1:0] THRESH_RST = LUM_W'(32768);

    typedef logic [LUM_W-1:0] lin_t;
    typedef lin_t lin_rom_t [256];

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic [LUM_W-1:0]   rem;     // partial remainder, always below den
        logic [RATIO_W-1:0] nq;      // numerator bits still to use, quotient bits shift in
        logic [LUM_W-1:0]   den;
        logic [LUM_W-1:0]   lum_a;
        logic [LUM_W-1:0]   lum_b;
        logic               light;
    } scr_cell_t;

    localparam int BIG_W = 320;

    // True when (m + 0.5) / 65536 <= (num / 269025) ^ 2.4, decided exactly by
    // raising both sides to the fifth power.
    function automatic logic half_below(input int unsigned m, input int unsigned num);
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        lhs = BIG_W'(1);
        rhs = BIG_W'(1);
        for (int i = 0; i < 5; i++)
        begin
            lhs = lhs * BIG_W'(2 * m + 1);
            rhs = rhs * BIG_W'(131072);
        end
        for (int i = 0; i < 12; i++)
        begin
            lhs = lhs * BIG_W'(269025);
            rhs = rhs * BIG_W'(num);
        end
        return lhs <= rhs;
    endfunction

    // Builds the table at elaboration: the linear segment below 0.04045 and
    // the power segment above, both rounded to nearest with ties up.
    function automatic lin_rom_t build_rom();
        lin_rom_t    rom;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned num;
        longint unsigned n;
        for (int c = 0; c < 256; c++)
        begin
            if (c <= 10)
            begin
                n = 64'(6553600) * 64'(c) * 64'd2 + 64'd329460;
                rom[c] = LUM_W'(n / 64'd658920);
            end
            else
            begin
                num = 1000 * c + 14025;
                lo  = 0;
                hi  = 65537;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (half_below(mid, num))
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                rom[c] = LUM_W'(lo);
            end
        end
        return rom;
    endfunction

    localparam lin_rom_t LIN_ROM = build_rom();

endpackage

[rtl/scr_luma.sv]
// ----------------------------------------------------------------------------
// scr_luma
// Three-stage relative luminance datapath for one color: table lookup,
// weighting, rounded sum.
// ----------------------------------------------------------------------------
module scr_luma
    import scr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [23:0]      color,
    output logic [LUM_W-1:0] lum
);

    logic [LUM_W-1:0]  r_reg, g_reg, b_reg;
    logic [PROD_W-1:0] pr_reg, pg_reg, pb_reg;
    logic [LUM_W-1:0]  lum_reg;
    logic [SUM_W-1:0]  sum;

    assign sum = SUM_W'(pr_reg) + SUM_W'(pg_reg) + SUM_W'(pb_reg) + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= LIN_ROM[color[23:16]];
            g_reg   <= LIN_ROM[color[15:8]];
            b_reg   <= LIN_ROM[color[7:0]];
            pr_reg  <= PROD_W'(r_reg) * PROD_W'(COEF_R);
            pg_reg  <= PROD_W'(g_reg) * PROD_W'(COEF_G);
            pb_reg  <= PROD_W'(b_reg) * PROD_W'(COEF_B);
            lum_reg <= sum[SUM_W-1:16];
        end
    end

    assign lum = lum_reg;

endmodule

[rtl/scr_div_cell.sv]
// ----------------------------------------------------------------------------
// scr_div_cell
// One restoring division step: develops one quotient bit and passes the
// item on to the next cell.
// ----------------------------------------------------------------------------
module scr_div_cell
    import scr_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  scr_cell_t d,
    output scr_cell_t q
);

    scr_cell_t      q_reg;
    scr_cell_t      q_next;
    logic [LUM_W:0] trial;
    logic [LUM_W:0] diff;
    logic           qbit;

    always_comb
    begin
        trial  = {d.rem, d.nq[RATIO_W-1]};
        diff   = trial - {1'b0, d.den};
        qbit   = (trial >= {1'b0, d.den});
        q_next = d;
        q_next.rem = qbit ? diff[LUM_W-1:0] : trial[LUM_W-1:0];
        q_next.nq  = {d.nq[RATIO_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[rtl/srgb_contrast_ratio_unit.sv]
// ----------------------------------------------------------------------------
// srgb_contrast_ratio_unit
// Relative luminance of two sRGB colors and their contrast ratio.
// ----------------------------------------------------------------------------
// The unit takes one pair of 24-bit colors per clock and returns the Q0.16
// relative luminance of each color, their contrast ratio in Q5.16 (floor of
// (lighter + 0.05) / (darker + 0.05)) and a flag that tells whether the
// first color is lighter than the programmed threshold. Table lookup,
// weighting and summing come first, then a register that orders the two
// luminances, then the divider, a row of cells that each settle one
// quotient bit. The pipeline moves as one: it holds while a finished result
// is offered and stalled, and otherwise takes a new transfer every cycle.
// The threshold register should be written only while no transfer is in
// flight; writes are always accepted.
module srgb_contrast_ratio_unit
    import scr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        color_a,
    input  logic [23:0]        color_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LUM_W-1:0]   luminance_a,
    output logic [LUM_W-1:0]   luminance_b,
    output logic [RATIO_W-1:0] contrast,
    output logic               a_is_light,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LUM_W-1:0]   cfg_data
);

    logic [N_STAGES-1:0] v_reg;
    logic [N_STAGES-1:0] v_next;
    logic [LUM_W-1:0]    thresh_reg;
    logic                adv;
    logic [LUM_W-1:0]    lum_a, lum_b;
    scr_cell_t           prep_reg;
    scr_cell_t           prep_next;
    scr_cell_t           chain [N_CELLS+1];
    logic [LUM_W-1:0]    hi, lo;
    logic [LUM_W-1:0]    hi_f;

    // Everything shifts unless the output holds a result that is stalled.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RST;
        else if (cfg_valid && cfg_ready)
            thresh_reg <= cfg_data;
    end

    assign v_next = {v_reg[N_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    scr_luma u_luma_a (.clk(clk), .en(adv), .color(color_a), .lum(lum_a));
    scr_luma u_luma_b (.clk(clk), .en(adv), .color(color_b), .lum(lum_b));

    // Order the two luminances and load the divider: the numerator is
    // (hi + flare) << 16, of which the top bits seed the remainder.
    always_comb
    begin
        hi   = (lum_a > lum_b) ? lum_a : lum_b;
        lo   = (lum_a > lum_b) ? lum_b : lum_a;
        hi_f = hi + FLARE;
        prep_next       = '0;
        prep_next.rem   = LUM_W'(hi_f[LUM_W-1:5]);
        prep_next.nq    = {hi_f[4:0], 16'd0};
        prep_next.den   = lo + FLARE;
        prep_next.lum_a = lum_a;
        prep_next.lum_b = lum_b;
        prep_next.light = (lum_a > thresh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prep_reg <= prep_next;
    end

    assign chain[0] = prep_reg;

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        scr_div_cell u_cell (.clk(clk), .en(adv), .d(chain[i]), .q(chain[i+1]));
    end

    assign out_valid   = v_reg[N_STAGES-1];
    assign luminance_a = chain[N_CELLS].lum_a;
    assign luminance_b = chain[N_CELLS].lum_b;
    assign contrast    = chain[N_CELLS].nq;
    assign a_is_light  = chain[N_CELLS].light;

`ifndef SYNTHESIS
    a_ratio_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> contrast >= RATIO_W'(65536))
        else $error("contrast ratio below 1.0");
    a_ratio_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> contrast <= RATIO_W'(1376256))
        else $error("contrast ratio above 21.0");
    a_equal_lum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && luminance_a == luminance_b) |-> contrast == RATIO_W'(65536))
        else $error("equal luminances must give a ratio of 1.0");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(contrast)))
        else $error("stalled result lost or changed");
`endif

endmodule
